// File: design/mfwp_pkg.sv
// Package: shared constants for the marker-framed word parser.
`timescale 1ns / 1ps
`default_nettype none
package mfwp_pkg;

  localparam int MAX_WORDS_DEF = 64;        // default frame store depth, header included

  localparam int WORD_W  = 32;              // received word width
  localparam int BYTE_W  = 8;               // header field width
  localparam int POS_W   = 6;               // value position field width
  localparam int FW_W    = 9;               // expected stored words: announced count + 1

  localparam logic [WORD_W-1:0] START_MARK = 32'h0000_002A;
  localparam logic [WORD_W-1:0] END_MARK   = 32'h0000_0023;

endpackage
`default_nettype wire

// File: design/mfwp_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module mfwp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/marker_framed_word_parser_top.sv
// Top level: marker-framed word parser with frame store and readout sequencer.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | word
//  out     | out_valid / out_ready| class_id, channel, param_index, value_count,
//          |                      | value, value_pos, has_value, last
//
//  Flow: words are taken while hunting, collecting or awaiting the end marker.
//  After a good end marker the block stops taking words and plays the frame
//  out: each stored value needs a RAM read state (ST_READ) and then an output
//  state (ST_OUT) that holds until out_ready; an empty frame goes straight to
//  the output state. The single RAM read port sets this.
//  Reset: rst (synchronous) returns the parser to hunting; the store is not cleared.
//  Stalls: out_ready low holds the current result; in_ready is low during readout.
//
module marker_framed_word_parser_top #(
  parameter int MAX_WORDS = mfwp_pkg::MAX_WORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mfwp_pkg::WORD_W-1:0]   word,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [mfwp_pkg::BYTE_W-1:0]   class_id,
  output logic      [mfwp_pkg::BYTE_W-1:0]   channel,
  output logic      [mfwp_pkg::BYTE_W-1:0]   param_index,
  output logic      [mfwp_pkg::BYTE_W-1:0]   value_count,
  output logic      [mfwp_pkg::WORD_W-1:0]   value,
  output logic      [mfwp_pkg::POS_W-1:0]    value_pos,
  output logic                               has_value,
  output logic                               last
);

  // Address width of the store and width of the stored-word counter.
  localparam int AW   = $clog2(MAX_WORDS);
  localparam int WT_W = $clog2(MAX_WORDS + 1);
  localparam int FW_W = mfwp_pkg::FW_W;
  localparam logic [WT_W-1:0] MAX_WT = WT_W'(MAX_WORDS);

  // Sequencer codes.
  localparam logic [2:0] ST_HUNT    = 3'd0;
  localparam logic [2:0] ST_COLLECT = 3'd1;
  localparam logic [2:0] ST_AWAIT   = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_OUT     = 3'd4;

  logic [2:0]                   state, state_next;
  logic [WT_W-1:0]              words_taken, words_taken_next;
  logic [FW_W-1:0]              frame_words, frame_words_next;
  logic [mfwp_pkg::WORD_W-1:0]  hdr, hdr_next;
  logic [AW-1:0]                cnt, cnt_next;   // number of stored values in the frame
  logic [AW-1:0]                pos, pos_next;   // value currently played out

  logic                         in_fire;
  logic                         ram_we;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [mfwp_pkg::WORD_W-1:0]  ram_rdata;

  logic [WT_W-1:0]              wt_inc;
  logic [WT_W-1:0]              wt_dec;
  logic [FW_W-1:0]              wt_inc_ext;
  logic [FW_W-1:0]              fw_eff;
  logic [AW-1:0]                pos_inc;

  assign in_ready   = (state == ST_HUNT) || (state == ST_COLLECT) || (state == ST_AWAIT);
  assign in_fire    = in_valid && in_ready;

  assign wt_inc     = words_taken + WT_W'(1);
  assign wt_dec     = words_taken - WT_W'(1);
  assign wt_inc_ext = {{(FW_W - WT_W){1'b0}}, wt_inc};
  // The header word sets the expected length in the same cycle it is stored.
  assign fw_eff     = (words_taken == '0)
                      ? ({1'b0, word[31:24]} + FW_W'(1)) : frame_words;
  assign pos_inc    = pos + AW'(1);

  // Frame store: entry 0 takes the header, entries 1.. the values.
  assign ram_we    = (state == ST_COLLECT) && in_fire;
  assign ram_re    = (state == ST_READ);
  assign ram_raddr = pos_inc;

  mfwp_ram #(
    .WIDTH (mfwp_pkg::WORD_W),
    .DEPTH (MAX_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (words_taken[AW-1:0]),
    .wdata (word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next       = state;
    words_taken_next = words_taken;
    frame_words_next = frame_words;
    hdr_next         = hdr;
    cnt_next         = cnt;
    pos_next         = pos;
    case (state)
      ST_HUNT: begin
        if (in_fire && (word == mfwp_pkg::START_MARK)) begin
          words_taken_next = '0;
          state_next       = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (in_fire) begin
          if (words_taken == '0) begin
            hdr_next = word;
          end
          frame_words_next = fw_eff;
          words_taken_next = wt_inc;
          // Stop at the announced length or when the store is full.
          if ((wt_inc_ext == fw_eff) || (wt_inc >= MAX_WT)) begin
            state_next = ST_AWAIT;
          end
        end
      end
      ST_AWAIT: begin
        if (in_fire) begin
          if (word == mfwp_pkg::END_MARK) begin
            cnt_next   = wt_dec[AW-1:0];
            pos_next   = '0;
            state_next = (wt_dec == '0) ? ST_OUT : ST_READ;
          end else begin
            // Drop the frame; this word is not checked as a start marker.
            state_next = ST_HUNT;
          end
        end
      end
      ST_READ: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (last) begin
            state_next = ST_HUNT;
          end else begin
            pos_next   = pos_inc;
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_HUNT;
      words_taken <= '0;
      frame_words <= '0;
    end else begin
      state       <= state_next;
      words_taken <= words_taken_next;
      frame_words <= frame_words_next;
    end
    hdr <= hdr_next;
    cnt <= cnt_next;
    pos <= pos_next;
  end

  // Result fields: header repeats on every result; value comes from the read register.
  assign out_valid   = (state == ST_OUT);
  assign class_id    = hdr[7:0];
  assign channel     = hdr[15:8];
  assign param_index = hdr[23:16];
  assign value_count = hdr[31:24];
  assign has_value   = (cnt != '0);
  assign value       = has_value ? ram_rdata : '0;
  assign value_pos   = {{(mfwp_pkg::POS_W - AW){1'b0}}, pos};
  assign last        = !has_value || (pos_inc == cnt);

  // Readout and intake never overlap.
  a_no_intake_in_readout: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a frame is played out");

  // The counter never runs past the store while collecting.
  a_collect_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COLLECT) |-> (words_taken < MAX_WT))
    else $error("frame store overrun");

  // An empty frame gives one flagged result with no value.
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_value) |-> (last && (value_pos == '0) && (value == '0)))
    else $error("malformed empty-frame result");

  // After a non-final result is taken, the next one needs a store read first.
  a_read_between: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (!out_valid && (state == ST_READ)))
    else $error("readout skipped the store read");

endmodule
`default_nettype wire
